[hw/rtl/utt_pkg.sv]
// Shared types, constants and the code point encoder of the UTF-16 to UTF-8 transcoder.
package utt_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned JOB_BYTES   = 6;

    localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
    localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;
    localparam logic [10:0] SUPP_OFFSET     = 11'h040;
    localparam logic [4:0] SURR_TOP         = 5'b11011;

    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } t_enc;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
    } t_job;

    function automatic t_enc encode_cp(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp[20:7] == '0) begin
            e.bytes[0] = {1'b0, cp[6:0]};
            e.count    = 3'd1;
        end else if (cp[20:11] == '0) begin
            e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_BYTE | {2'b00, cp[5:0]};
            e.count    = 3'd2;
        end else if (cp[20:16] == '0) begin
            e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT_BYTE | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_BYTE | {2'b00, cp[5:0]};
            e.count    = 3'd3;
        end else begin
            e.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT_BYTE | {2'b00, cp[17:12]};
            e.bytes[2] = CONT_BYTE | {2'b00, cp[11:6]};
            e.bytes[3] = CONT_BYTE | {2'b00, cp[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

endpackage

[hw/rtl/utt_ifs.sv]
// Request channel interfaces for UTF-16 code units in and UTF-8 bytes out.
interface utt_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface utt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output run_last, output text_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input text_end,
                    output ready);
endinterface

[hw/rtl/utt_front.sv]
// Front end: accepts code units, pairs surrogates and builds byte jobs for the queue.
module utt_front
    import utt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    utt_unit_if.sink     i_in_req,
    input  logic         i_q_full,
    output logic         o_push,
    output t_job         o_push_job
);

    logic       r_held_valid;
    logic [9:0] r_held_bits;
    logic       n_held_valid;
    logic [9:0] n_held_bits;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        pair;
    logic        flush;
    logic        emit_new;
    logic [10:0] plane;
    logic [20:0] cp;
    t_enc        enc_new;
    t_enc        enc_held;
    t_job        job;

    assign i_in_req.ready = !i_q_full;
    assign accept  = i_in_req.valid && !i_q_full;
    assign is_high = i_in_req.code_unit[15:10] == HIGH_SURR_PREFIX;
    assign is_low  = i_in_req.code_unit[15:10] == LOW_SURR_PREFIX;
    assign pair    = r_held_valid && is_low;
    assign flush   = r_held_valid && !is_low;
    assign emit_new = pair || !(is_high && !i_in_req.last_unit);
    assign plane   = 11'({1'b0, r_held_bits}) + SUPP_OFFSET;

    always_comb begin
        if (pair) begin
            cp = {plane, i_in_req.code_unit[9:0]};
        end else begin
            cp = {5'd0, i_in_req.code_unit};
        end
    end

    assign enc_new  = encode_cp(cp);
    assign enc_held = encode_cp({5'd0, SURR_TOP, 1'b0, r_held_bits});

    always_comb begin
        job       = '0;
        job.last  = i_in_req.last_unit;
        if (flush) begin
            job.bytes[0] = enc_held.bytes[0];
            job.bytes[1] = enc_held.bytes[1];
            job.bytes[2] = enc_held.bytes[2];
            job.bytes[3] = enc_new.bytes[0];
            job.bytes[4] = enc_new.bytes[1];
            job.bytes[5] = enc_new.bytes[2];
            job.count    = emit_new ? 3'(3'd3 + enc_new.count) : 3'd3;
        end else begin
            job.bytes[0] = enc_new.bytes[0];
            job.bytes[1] = enc_new.bytes[1];
            job.bytes[2] = enc_new.bytes[2];
            job.bytes[3] = enc_new.bytes[3];
            job.count    = emit_new ? enc_new.count : 3'd0;
        end
    end

    assign o_push     = accept && (job.count != 3'd0);
    assign o_push_job = job;

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        if (accept) begin
            n_held_valid = is_high && !i_in_req.last_unit;
            n_held_bits  = n_held_valid ? i_in_req.code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

endmodule

[hw/rtl/utt_queue.sv]
// Small job queue that decouples the front end from the byte serialiser.
module utt_queue
    import utt_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_slots [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_full       = r_count == CW'(DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head_job   = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hw/rtl/utt_back.sv]
// Back end: takes byte jobs from the queue and sends them one byte per cycle while the output is ready.
module utt_back
    import utt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_job        i_head_job,
    output logic        o_pop,
    utt_byte_if.source  o_out_req
);

    t_job       r_job;
    logic [2:0] r_idx;
    logic       r_busy;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_last;
    logic       r_text_end;

    logic       advance;
    logic       final_byte;

    assign advance    = r_busy && (!r_out_valid || o_out_req.ready);
    assign final_byte = r_idx == 3'(r_job.count - 3'd1);
    assign o_pop      = i_head_valid && (!r_busy || (advance && final_byte));

    assign o_out_req.valid    = r_out_valid;
    assign o_out_req.out_byte = r_out_byte;
    assign o_out_req.run_last = r_run_last;
    assign o_out_req.text_end = r_text_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (advance && final_byte) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_idx <= 3'(r_idx + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_req.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= r_job.bytes[r_idx];
            r_run_last <= final_byte;
            r_text_end <= final_byte && r_job.last;
        end
    end

endmodule

[hw/rtl/utf16_to_utf8_transcoder_core.sv]
// Top level of the UTF-16 to UTF-8 transcoder.
// The first byte of a code unit passes the job queue, the back-end job register and the
// output register. Output is one byte per cycle while the output is ready, through the
// single byte-wide output register; a unit gives up to four bytes (up to six when a held surrogate is flushed).
// A code unit is accepted every cycle while the job queue has room.
// Reset is synchronous and active low; it clears the held surrogate, the queue and output valid.
module utf16_to_utf8_transcoder_core
    import utt_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    utt_unit_if.sink    i_in_req,
    utt_byte_if.source  o_out_req
);

    logic q_full;
    logic push;
    t_job push_job;
    logic pop;
    logic head_valid;
    t_job head_job;

    utt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_req   (i_in_req),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_job (push_job)
    );

    utt_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_job   (push_job),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head_job   (head_job)
    );

    utt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_job   (head_job),
        .o_pop        (pop),
        .o_out_req    (o_out_req)
    );

endmodule

[hw/rtl/utt_checker.sv]
// Port-level assertions for the transcoder and their binding to the top level.
module utt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_run_last,
    input logic       i_text_end
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output request valid after reset.");

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_text_end |-> i_run_last)
        else $error("End of text on a byte that does not close its run.");

    a_ascii_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_byte[7] |-> i_run_last)
        else $error("Single-byte sequence not marked as the end of its run.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_run_last))
        else $error("Stalled output request changed.");

endmodule

bind utf16_to_utf8_transcoder_core utt_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_req.valid),
    .i_out_ready (o_out_req.ready),
    .i_out_byte  (o_out_req.out_byte),
    .i_run_last  (o_out_req.run_last),
    .i_text_end  (o_out_req.text_end)
);
